@@ rtl/raau_pkg.sv @@
`timescale 1ns / 1ps
package raau_pkg;

	localparam int WordBits = 64;

	typedef logic [WordBits-1:0] word_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_BAD = 2'd3
	} opcode_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic  direct;    // result is already known
		logic  do_mul;    // multiply, else ratio add
		logic  mul_int;   // integer multiply, product is the result
		word_t n1;
		word_t d1;
		word_t n2;
		word_t d2;
		logic  ratio;     // result flag when direct
	} job_t;

	function automatic logic is_neg(input word_t x);
		is_neg = x[WordBits-1];
	endfunction

	function automatic word_t magn(input word_t x);
		magn = x[WordBits-1] ? (word_t'(0) - x) : x;
	endfunction

endpackage

@@ rtl/raau_divider.sv @@
`timescale 1ns / 1ps
// Signed truncating divider, one quotient bit per cycle
module raau_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  raau_pkg::word_t  dividend,
	input  raau_pkg::word_t  divisor,
	output logic             done,
	output raau_pkg::word_t  quot,
	output raau_pkg::word_t  rem
);
	import raau_pkg::*;

	localparam int CntBits = $clog2(WordBits + 1);

	logic [CntBits-1:0] cnt_q;
	logic               run_q;
	word_t              q_q;
	word_t              r_q;
	word_t              d_q;
	word_t              n_q;
	logic               nneg_q;
	logic               qneg_q;
	logic               dz_q;
	logic [WordBits:0]  trial;

	assign trial = {r_q, q_q[WordBits-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				cnt_q  <= CntBits'(WordBits);
				q_q    <= magn(dividend);
				r_q    <= '0;
				d_q    <= magn(divisor);
				n_q    <= dividend;
				nneg_q <= is_neg(dividend);
				qneg_q <= is_neg(dividend) ^ is_neg(divisor);
				dz_q   <= (divisor == '0);
			end else if (run_q) begin
				if (trial[WordBits]) begin
					r_q <= {r_q[WordBits-2:0], q_q[WordBits-1]};
					q_q <= {q_q[WordBits-2:0], 1'b0};
				end else begin
					r_q <= trial[WordBits-1:0];
					q_q <= {q_q[WordBits-2:0], 1'b1};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntBits'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (dz_q) begin
			quot = '0;
			rem  = n_q;
		end else begin
			quot = qneg_q ? (word_t'(0) - q_q) : q_q;
			rem  = nneg_q ? (word_t'(0) - r_q) : r_q;
		end
	end

	// done is a single pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_no_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && !go |=> run_q || done) else $error("divider lost");
	a_cnt_run: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q && !go |=> !run_q) else $error("spurious run");

endmodule

@@ rtl/raau_front.sv @@
`timescale 1ns / 1ps
// Front: sign handling, shortcuts, integer add/sub results, queue of classified jobs
module raau_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [1:0]            opcode,
	input  logic signed [63:0]    a_num,
	input  logic [62:0]           a_den,
	input  logic                  a_is_ratio,
	input  logic signed [63:0]    b_num,
	input  logic [62:0]           b_den,
	input  logic                  b_is_ratio,
	output logic                  full,
	output logic                  job_valid,
	output raau_pkg::job_t        job,
	input  logic                  job_pop
);
	import raau_pkg::*;

	localparam int Depth = 2;

	job_t       q_mem [Depth];
	logic [0:0] wp_q;
	logic [0:0] rp_q;
	logic [1:0] cnt_q;
	job_t       cls;
	word_t      an, bn, ad, bd;
	logic       anyr;

	assign an   = word_t'(a_num);
	assign bn   = word_t'(b_num);
	assign ad   = a_is_ratio ? word_t'({1'b0, a_den}) : word_t'(1);
	assign bd   = b_is_ratio ? word_t'({1'b0, b_den}) : word_t'(1);
	assign anyr = a_is_ratio | b_is_ratio;

	// classify one item
	always_comb begin
		cls        = '0;
		cls.direct = 1'b1;
		cls.d1     = word_t'(1);
		unique case (opcode_t'(opcode))
			OP_ADD: begin
				priority if (an == '0) begin
					cls.n1 = bn; cls.d1 = bd; cls.ratio = b_is_ratio;
				end else if (bn == '0) begin
					cls.n1 = an; cls.d1 = ad; cls.ratio = a_is_ratio;
				end else if (!anyr) begin
					cls.n1 = an + bn;
				end else begin
					cls.direct = 1'b0;
					cls.n1 = an; cls.d1 = ad; cls.n2 = bn; cls.d2 = bd;
				end
			end
			OP_SUB: begin
				if (!anyr) begin
					cls.n1 = an - bn;
				end else begin
					cls.direct = 1'b0;
					cls.n1 = an; cls.d1 = ad; cls.n2 = word_t'(0) - bn; cls.d2 = bd;
				end
			end
			OP_MUL: begin
				priority if (an == '0) begin
					cls.n1 = an; cls.d1 = ad; cls.ratio = a_is_ratio;
				end else if (bn == '0) begin
					cls.n1 = bn; cls.d1 = bd; cls.ratio = b_is_ratio;
				end else if (!anyr) begin
					// product formed by the back end multiplier
					cls.direct  = 1'b0;
					cls.do_mul  = 1'b1;
					cls.mul_int = 1'b1;
					cls.n1 = an; cls.n2 = bn;
				end else begin
					cls.direct = 1'b0;
					cls.do_mul = 1'b1;
					cls.n1 = an; cls.d1 = ad; cls.n2 = bn; cls.d2 = bd;
				end
			end
			OP_BAD: begin
				cls.n1 = '0;
			end
			default: cls.n1 = '0;
		endcase
	end

	assign full      = (cnt_q == 2'(Depth));
	assign job_valid = (cnt_q != '0);
	assign job       = q_mem[rp_q];

	always_ff @(posedge clk) begin
		if (take) q_mem[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (take) wp_q <= wp_q + 1'b1;
			if (job_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 2'(take) - 2'(job_pop);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !take) else $error("queue overflow");
	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid) else $error("queue underflow");
	a_cnt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(Depth)) else $error("bad count");

endmodule

@@ rtl/raau_back.sv @@
`timescale 1ns / 1ps
// Back: products, lcm scaling, gcd and reduction sequencer over one shared divider
// and one shared multiplier
module raau_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	input  raau_pkg::job_t        job,
	output logic                  job_pop,
	output logic                  idle,
	output logic                  done,
	output logic signed [63:0]    result_num,
	output logic signed [63:0]    result_den,
	output logic                  result_is_ratio
);
	import raau_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_MN   = 15'b000000000000010,  // n1*n2
		S_MD   = 15'b000000000000100,  // d1*d2
		S_G1   = 15'b000000000001000,  // gcd(d1,d2)
		S_LQ   = 15'b000000000010000,  // d1/g
		S_LM   = 15'b000000000100000,  // lcm = q*d2
		S_K1   = 15'b000000001000000,  // k1 = lcm/d1
		S_K2   = 15'b000000010000000,  // k2 = lcm/d2
		S_SN1  = 15'b000000100000000,  // n1*k1
		S_SD   = 15'b000001000000000,  // d1*k1
		S_SN2  = 15'b000010000000000,  // n2*k2, added to n1*k1
		S_SUM  = 15'b000100000000000,
		S_G2   = 15'b001000000000000,  // gcd(num,den)
		S_RN   = 15'b010000000000000,
		S_RD   = 15'b100000000000000
	} state_t;

	state_t      st_q;
	word_t       n1_q, d1_q, n2_q, d2_q;
	word_t       m_q, n_q, keep_q, t_q;
	word_t       num_q, den_q, nq_q, k2_q;
	logic        mul_int_q;
	logic        div_go, div_done, wait_q;
	word_t       dv_a, dv_b, quot, rem;
	logic        mul_go, mul_done, mwait_q, mrun_q;
	logic [1:0]  mcnt_q;
	word_t       mv_a, mv_b, ma_q, mb_q, macc_q, prod;
	logic [79:0] mpart;
	logic        gt1;

	raau_divider u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(dv_a), .divisor(dv_b),
		.done(div_done), .quot(quot), .rem(rem)
	);

	assign idle    = (st_q == S_IDLE);
	assign job_pop = idle && job_valid;
	assign gt1     = $signed(keep_q) > $signed(word_t'(1));

	// divider operand select
	always_comb begin
		dv_a = n_q;
		dv_b = m_q;
		unique case (st_q)
			S_LQ:    begin dv_a = d1_q;  dv_b = keep_q; end
			S_K1:    begin dv_a = t_q;   dv_b = d1_q; end
			S_K2:    begin dv_a = t_q;   dv_b = d2_q; end
			S_RN:    begin dv_a = num_q; dv_b = keep_q; end
			S_RD:    begin dv_a = den_q; dv_b = keep_q; end
			default: begin dv_a = n_q;   dv_b = m_q; end
		endcase
	end

	// divider launch, once per state visit or gcd step
	always_comb begin
		unique case (st_q)
			S_G1, S_G2:             div_go = !wait_q && (m_q != '0);
			S_LQ, S_K1, S_K2, S_RD: div_go = !wait_q;
			S_RN:                   div_go = !wait_q && gt1;
			default:                div_go = 1'b0;
		endcase
	end

	// multiplier operand select
	always_comb begin
		unique case (st_q)
			S_MD:    begin mv_a = d1_q; mv_b = d2_q; end
			S_LM:    begin mv_a = t_q;  mv_b = d2_q; end
			S_SN1:   begin mv_a = n1_q; mv_b = nq_q; end
			S_SD:    begin mv_a = d1_q; mv_b = nq_q; end
			S_SN2:   begin mv_a = n2_q; mv_b = k2_q; end
			default: begin mv_a = n1_q; mv_b = n2_q; end
		endcase
	end

	always_comb begin
		unique case (st_q)
			S_MN, S_MD, S_LM, S_SN1, S_SD, S_SN2: mul_go = !mwait_q;
			default:                              mul_go = 1'b0;
		endcase
	end

	// multiplier: low word of the product, 16 bits of b per cycle
	assign mpart = {16'd0, ma_q} * {64'd0, mb_q[15:0]};
	assign prod  = macc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrun_q   <= 1'b0;
			mul_done <= 1'b0;
			mcnt_q   <= '0;
		end else begin
			mul_done <= 1'b0;
			if (mul_go) begin
				mrun_q <= 1'b1;
				mcnt_q <= 2'd3;
				ma_q   <= mv_a;
				mb_q   <= mv_b;
				macc_q <= '0;
			end else if (mrun_q) begin
				macc_q <= macc_q + mpart[63:0];
				ma_q   <= {ma_q[47:0], 16'd0};
				mb_q   <= {16'd0, mb_q[63:16]};
				mcnt_q <= mcnt_q - 1'b1;
				if (mcnt_q == 2'd0) begin
					mrun_q   <= 1'b0;
					mul_done <= 1'b1;
				end
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			wait_q  <= 1'b0;
			mwait_q <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (div_go) wait_q <= 1'b1;
			if (div_done) wait_q <= 1'b0;
			if (mul_go) mwait_q <= 1'b1;
			if (mul_done) mwait_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (job_valid) begin
					n1_q <= job.n1; d1_q <= job.d1; n2_q <= job.n2; d2_q <= job.d2;
					mul_int_q <= job.mul_int;
					if (job.direct) begin
						result_num      <= job.n1;
						result_den      <= job.d1;
						result_is_ratio <= job.ratio;
						done            <= 1'b1;
					end else if (job.do_mul) begin
						st_q <= S_MN;
					end else if (job.d1 == job.d2) begin
						num_q <= job.n1 + job.n2; den_q <= job.d1;
						st_q  <= S_SUM;
					end else begin
						m_q <= job.d1; n_q <= job.d2; keep_q <= job.d2;
						st_q <= S_G1;
					end
				end
				S_MN: if (mul_done) begin
					if (mul_int_q) begin
						result_num      <= prod;
						result_den      <= word_t'(1);
						result_is_ratio <= 1'b0;
						done            <= 1'b1;
						st_q            <= S_IDLE;
					end else begin
						num_q <= prod;
						st_q  <= S_MD;
					end
				end
				S_MD: if (mul_done) begin den_q <= prod; st_q <= S_SUM; end
				S_G1, S_G2: begin
					if (m_q == '0) begin
						st_q <= (st_q == S_G1) ? S_LQ : S_RN;
					end else if (div_done) begin
						keep_q <= m_q;
						n_q    <= m_q;
						m_q    <= rem;
					end
				end
				S_LQ: if (div_done) begin t_q <= quot; st_q <= S_LM; end
				S_LM: if (mul_done) begin t_q <= prod; st_q <= S_K1; end
				S_K1: if (div_done) begin nq_q <= quot; st_q <= S_K2; end
				S_K2: if (div_done) begin k2_q <= quot; st_q <= S_SN1; end
				S_SN1: if (mul_done) begin num_q <= prod; st_q <= S_SD; end
				S_SD: if (mul_done) begin den_q <= prod; st_q <= S_SN2; end
				S_SN2: if (mul_done) begin num_q <= num_q + prod; st_q <= S_SUM; end
				S_SUM: begin
					m_q <= num_q;
					n_q <= den_q; keep_q <= den_q;
					st_q <= S_G2;
				end
				S_RN: begin
					if (!gt1) begin
						result_num <= num_q; result_den <= den_q;
						result_is_ratio <= 1'b1; done <= 1'b1; st_q <= S_IDLE;
					end else if (div_done) begin
						nq_q <= quot; st_q <= S_RD;
					end
				end
				S_RD: if (div_done) begin
					result_num      <= nq_q;
					result_den      <= quot;
					result_is_ratio <= (quot != word_t'(1));
					done            <= 1'b1;
					st_q            <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("bad state");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> st_q == S_IDLE) else $error("pop while busy");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(wait_q && mwait_q)) else $error("divider and multiplier both pending");
	a_mul_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |=> !mul_done) else $error("multiplier done held");

endmodule

@@ rtl/rational_add_sub_mul_unit.sv @@
`timescale 1ns / 1ps
// Channel | Signals                                          | Beat accepted when
// input   | opcode a_num a_den a_is_ratio b_num b_den b_is_ratio | start && !busy
// result  | result_num result_den result_is_ratio             | done (one cycle)
// Direct results (shortcuts, integer add/sub, bad opcode) are queued at the
// accepting edge and registered with done when the idle back end takes them;
// integer multiply first passes the shared multiplier. A ratio item takes one
// divider pass per Euclid step of both gcds plus up to 5 further divides.
// Reset is asynchronous, active low, and clears all control state.
// A two-entry queue lets new items in while the back end works; busy
// rises only when it is full. The receiver cannot stall results.
module rational_add_sub_mul_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic signed [63:0] a_num,
	input  logic [62:0]        a_den,
	input  logic               a_is_ratio,
	input  logic signed [63:0] b_num,
	input  logic [62:0]        b_den,
	input  logic               b_is_ratio,
	output logic               done,
	output logic signed [63:0] result_num,
	output logic signed [63:0] result_den,
	output logic               result_is_ratio
);
	import raau_pkg::*;

	logic  full, job_valid, job_pop, back_idle;
	job_t  job;

	assign busy = full;

	raau_front u_front (
		.clk(clk), .arst_n(arst_n), .take(start && !busy), .opcode(opcode),
		.a_num(a_num), .a_den(a_den), .a_is_ratio(a_is_ratio),
		.b_num(b_num), .b_den(b_den), .b_is_ratio(b_is_ratio),
		.full(full), .job_valid(job_valid), .job(job), .job_pop(job_pop)
	);

	raau_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job),
		.job_pop(job_pop), .idle(back_idle), .done(done),
		.result_num(result_num), .result_den(result_den),
		.result_is_ratio(result_is_ratio)
	);

	a_idle_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> back_idle) else $error("result outside idle");

endmodule
